/* rtl/twelve_hour_clock_calendar_macros.svh */
// assertion helpers shared by the clock calendar modules
`ifndef TWELVE_HOUR_CLOCK_CALENDAR_MACROS_SVH
`define TWELVE_HOUR_CLOCK_CALENDAR_MACROS_SVH

// same-cycle implication, checked outside reset
`define THCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thcc check failed");

// next-cycle implication, checked outside reset
`define THCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thcc check failed");

`endif

/* rtl/thcc_pkg.sv */
package thcc_pkg;

  // time of day as carried between modules
  typedef struct packed {
    logic [3:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       afternoon;
  } thcc_time_t;

  // calendar date
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } thcc_date_t;

  // counter limits
  localparam logic [6:0] SEC_WRAP    = 7'd60;
  localparam logic [6:0] MIN_LAST    = 7'd59;
  localparam logic [3:0] HOUR_ELEVEN = 4'd11;
  localparam logic [3:0] HOUR_TWELVE = 4'd12;
  localparam logic [3:0] HOUR_ONE    = 4'd1;
  localparam logic [4:0] MONTH_LAST  = 5'd12;
  localparam logic [3:0] MONTH_ONE   = 4'd1;
  localparam logic [4:0] DAY_ONE     = 5'd1;

  // month codes with short lengths
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;

  localparam logic [4:0] DAYS_SHORT = 5'd28;
  localparam logic [4:0] DAYS_MID   = 5'd30;
  localparam logic [4:0] DAYS_LONG  = 5'd31;

  // state after reset
  localparam thcc_time_t TIME_RESET = '{
    hours: 4'd11, minutes: 6'd24, seconds: 6'd0, afternoon: 1'b1
  };
  localparam thcc_date_t DATE_RESET = '{
    day: 5'd30, month: 4'd4, year: 16'd2000
  };

  // month length, no leap years
  function automatic logic [4:0] days_in_month(input logic [3:0] month);
    logic [4:0] days;
    days = DAYS_LONG;
    if (month == MONTH_FEB) begin
      days = DAYS_SHORT;
    end else if (month == MONTH_APR || month == MONTH_JUN ||
                 month == MONTH_SEP || month == MONTH_NOV) begin
      days = DAYS_MID;
    end
    return days;
  endfunction

endpackage

/* rtl/thcc_time.sv */
`include "twelve_hour_clock_calendar_macros.svh"

module thcc_time (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  output thcc_pkg::thcc_time_t time_nxt,
  output logic                day_adv
);
  import thcc_pkg::*;

  thcc_time_t time_r;
  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic       sec_wrap;
  logic       min_wrap;

  // carry chain seconds -> minutes -> hours
  assign sec_inc  = {1'b0, time_r.seconds} + 7'd1;
  assign min_inc  = {1'b0, time_r.minutes} + 7'd1;
  assign sec_wrap = (sec_inc >= SEC_WRAP);
  assign min_wrap = (min_inc > MIN_LAST);

  always_comb begin
    time_nxt = time_r;
    day_adv  = 1'b0;
    if (step) begin
      time_nxt.seconds = sec_inc[5:0];
      if (sec_wrap) begin
        time_nxt.seconds = '0;
        time_nxt.minutes = min_inc[5:0];
        if (min_wrap) begin
          time_nxt.minutes = '0;
          // am/pm flips only going from eleven to twelve
          if (time_r.hours == HOUR_ELEVEN) begin
            time_nxt.hours     = HOUR_TWELVE;
            time_nxt.afternoon = ~time_r.afternoon;
            day_adv            = time_r.afternoon;
          end else if (time_r.hours >= HOUR_TWELVE) begin
            time_nxt.hours = HOUR_ONE;
          end else begin
            time_nxt.hours = time_r.hours + 4'd1;
          end
        end
      end
    end
  end

  // time of day state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= TIME_RESET;
    end else begin
      time_r <= time_nxt;
    end
  end

  `THCC_ASSERT_NOW(a_day_adv_at_midnight, day_adv, step && time_r.afternoon && time_r.hours == HOUR_ELEVEN)
  `THCC_ASSERT_NOW(a_hour_range, 1'b1, time_r.hours != 4'd0 && time_r.hours <= HOUR_TWELVE)
  `THCC_ASSERT_NEXT(a_hold_without_step, !step, $stable(time_r))

endmodule

/* rtl/thcc_date.sv */
module thcc_date (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                day_adv,
  output thcc_pkg::thcc_date_t date_nxt
);
  import thcc_pkg::*;

  thcc_date_t date_r;
  logic [4:0] month_inc;
  logic       month_end;

  assign month_inc = {1'b0, date_r.month} + 5'd1;
  assign month_end = (date_r.day >= days_in_month(date_r.month));

  // day -> month -> year carry
  always_comb begin
    date_nxt = date_r;
    if (day_adv) begin
      if (month_end) begin
        date_nxt.day   = DAY_ONE;
        date_nxt.month = month_inc[3:0];
        if (month_inc > MONTH_LAST) begin
          date_nxt.month = MONTH_ONE;
          date_nxt.year  = date_r.year + 16'd1;
        end
      end else begin
        date_nxt.day = date_r.day + 5'd1;
      end
    end
  end

  // calendar state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      date_r <= DATE_RESET;
    end else begin
      date_r <= date_nxt;
    end
  end

endmodule

/* rtl/twelve_hour_clock_calendar.sv */
// Twelve-hour clock with day/month/year calendar (no leap years).
// Input channel: in_valid/in_ready with in_second_tick. Every request is
// taken; a request with the tick set advances the time by one second while
// the clock runs, and yields one result with the updated time and date.
// A request without the tick, or any request while stopped, yields nothing.
// Config channel: cfg_valid/cfg_ready carries cfg_clock_running; it is
// always ready and should be written only while no result is pending.
// Output channel: out_valid/out_ready with hours, minutes, seconds, am/pm
// flag and date, held in an output register.
// Results are registered, visible in the cycle after the request is taken.
// Throughput: one request per cycle unless stalled; the carry chain through
// the time and date counters completes in the cycle the request is taken.
// Stall: while a result waits and out_ready is low, in_ready drops; it
// rises again in the cycle the result is taken.
// Reset (synchronous, rst_n low): time 11:24:00 PM, 30 April 2000, clock
// running, no result pending.
`include "twelve_hour_clock_calendar_macros.svh"

module twelve_hour_clock_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_second_tick,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_clock_running,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_hours,
  output logic [5:0]  out_minutes,
  output logic [5:0]  out_seconds,
  output logic        out_afternoon,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month_number,
  output logic [15:0] out_year_number
);
  import thcc_pkg::*;

  logic       running_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       in_accept;
  logic       step;
  logic       day_adv;
  thcc_time_t time_nxt;
  thcc_date_t date_nxt;
  thcc_time_t time_out_r;
  thcc_date_t date_out_r;

  // handshake: accept while the output slot is free or draining
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign step      = in_accept && in_second_tick && running_r;
  assign cfg_ready = 1'b1;

  thcc_time u_time (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .time_nxt (time_nxt),
    .day_adv  (day_adv)
  );

  thcc_date u_date (
    .clk      (clk),
    .rst_n    (rst_n),
    .day_adv  (day_adv),
    .date_nxt (date_nxt)
  );

  // run/stop register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      running_r <= cfg_clock_running;
    end
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step) begin
      time_out_r <= time_nxt;
      date_out_r <= date_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hours        = time_out_r.hours;
  assign out_minutes      = time_out_r.minutes;
  assign out_seconds      = time_out_r.seconds;
  assign out_afternoon    = time_out_r.afternoon;
  assign out_day_of_month = date_out_r.day;
  assign out_month_number = date_out_r.month;
  assign out_year_number  = date_out_r.year;

  `THCC_ASSERT_NEXT(a_step_gives_result, step, out_valid_r)
  `THCC_ASSERT_NOW(a_stall_blocks_input, out_valid_r && !out_ready, !in_ready)
  `THCC_ASSERT_NEXT(a_no_result_without_step, !out_valid_r && !step, !out_valid_r)

endmodule
